/* hdl/spr_pkg.sv */
// ---------------------------------------------------------------------------
// spr_pkg: shared definitions for shading projection removal
// Item types, operation and register codes, fixed-point shifts and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

    localparam int DEFAULT_PIXEL_COUNT = 16384;
    localparam int IDX_W               = 14;

    localparam int SHADE_SHIFT   = 13;
    localparam int SHADE4_SHIFT  = 13;
    localparam int OUT_SHIFT     = 10;
    localparam int SUM_SHIFT     = 10;
    localparam int SH_DIFF       = SHADE4_SHIFT - SHADE_SHIFT;
    localparam int RES_SHIFT     = 2 * SHADE4_SHIFT;
    localparam int ACC_SHIFT     = SUM_SHIFT - SHADE4_SHIFT;

    // stored pixel word: pattern, shade, shade4
    localparam int MEM_W = 16 + 32 + 32;

    localparam int DIV_W = 64;

    localparam logic [31:0] RST_SUM_SQ    = 32'd15567050;
    localparam logic [31:0] RST_SUM_CROSS = 32'd11981357;
    localparam logic [31:0] RST_SUM4_SQ   = 32'd10135232;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SOLVE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_SUM_SQ    = 2'd0,
        CFG_SUM_CROSS = 2'd1,
        CFG_SUM4_SQ   = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         operation;
        logic [IDX_W-1:0]   pixel_index;
        logic signed [15:0] pattern_value;
        logic signed [31:0] shade_value;
        logic signed [31:0] shade4_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] corrected_value;
        logic signed [63:0] alpha_coef;
        logic signed [63:0] beta_coef;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [63:0] den;
    } t_div_req;

    function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
        return {x[31], x};
    endfunction

    // shift left for a positive count, arithmetic right for a negative one
    function automatic logic signed [63:0] shift_by(input logic signed [63:0] x,
                                                    input int k);
        if (k >= 0) return x <<< k;
        else return x >>> (-k);
    endfunction

    // shade operand of the alpha product; a left shift is applied after the product
    function automatic logic signed [32:0] shade_pre(input logic signed [31:0] s);
        logic signed [63:0] w;
        w = 64'(s);
        if (SH_DIFF < 0) return 33'(w >>> (-SH_DIFF));
        else return sx33(s);
    endfunction

    function automatic logic signed [63:0] shade_post(input logic signed [63:0] x);
        if (SH_DIFF > 0) return x <<< SH_DIFF;
        else return x;
    endfunction

endpackage

`default_nettype wire

/* hdl/spr_ram.sv */
// ---------------------------------------------------------------------------
// spr_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle, read data in the cycle after.
// ---------------------------------------------------------------------------
`default_nettype none

module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/spr_mul.sv */
// ---------------------------------------------------------------------------
// spr_mul: 64 x 33 multiplier, low 64 bits of the product
// Two partial products in the first stage, their sum in the second.
// ---------------------------------------------------------------------------
`default_nettype none

module spr_mul (
    input  wire                      i_clk,
    input  wire [63:0]               i_a,
    input  wire signed [32:0]        i_b,
    output logic signed [63:0]       o_p
);

    logic signed [65:0] w_lo;
    logic signed [65:0] w_hi;
    logic [63:0]        r_lo;
    logic [31:0]        r_hi;

    // a = signed high word * 2^32 + unsigned low word
    assign w_lo = $signed({1'b0, i_a[31:0]}) * i_b;
    assign w_hi = $signed(i_a[63:32]) * i_b;

    always_ff @(posedge i_clk) begin
        r_lo <= w_lo[63:0];
        r_hi <= w_hi[31:0];
        o_p  <= $signed(r_lo + {r_hi, 32'd0});
    end

endmodule

`default_nettype wire

/* hdl/spr_div.sv */
// ---------------------------------------------------------------------------
// spr_div: 64-bit signed divider, one quotient bit per cycle
// Truncates toward zero; a zero divisor gives zero.
// ---------------------------------------------------------------------------
`default_nettype none

module spr_div (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  spr_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic signed [63:0]        o_quot
);

    localparam int W     = spr_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;
    logic             r_neg;
    logic             r_zero;
    logic [W:0]       w_rem_sh;
    logic             w_ge;
    logic [W:0]       w_sub;

    assign w_rem_sh = {r_rem, r_quo[W-1]};
    assign w_sub    = w_rem_sh - {1'b0, r_den};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.num[W-1] ? W'(-i_req.num) : W'(i_req.num);
                r_den  <= i_req.den[W-1] ? W'(-i_req.den) : W'(i_req.den);
                r_neg  <= i_req.num[W-1] ^ i_req.den[W-1];
                r_zero <= (i_req.den == '0);
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[W-1:0] : w_rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], w_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // most negative / -1 wraps back to itself through the negation
    assign o_quot = r_zero ? '0 : (r_neg ? $signed(-r_quo) : $signed(r_quo));

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("divider done while still iterating");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CNT_W'(W - 1) && !i_req.start) |=> o_done)
        else $error("divider missed its done pulse");
`endif

endmodule

`default_nettype wire

/* hdl/shading_projection_removal.sv */
// ---------------------------------------------------------------------------
// shading_projection_removal: two-basis least-squares shading removal
// Stores pixels in one RAM, solves beta and alpha, returns corrected pixels.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_stall    i_in_data   (t_in_item)
//  out      output     o_out_valid / i_out_stall  o_out_data  (t_out_item)
//  cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
//  One item at a time. Load, no-op and out-of-range items go from idle straight
//  to the output step. Read: RAM read, 2-stage multiply, sum, output. Solve:
//  a first pass of the bit-serial divider, then per loaded pixel a RAM read and
//  two dependent multiplies, then a second pass of the divider.
//  Synchronous active-low reset clears control, coefficients and dot products;
//  the pixel RAM is not cleared. A new item is taken while a result waits in
//  the output register, as long as that result is transferred by then.
// ---------------------------------------------------------------------------
`default_nettype none

module shading_projection_removal #(
    parameter int PIXEL_COUNT = spr_pkg::DEFAULT_PIXEL_COUNT
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  spr_pkg::t_in_item        i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output spr_pkg::t_out_item       o_out_data,
    input  wire                      i_cfg_we,
    input  wire [1:0]                i_cfg_idx,
    input  wire [31:0]               i_cfg_wdata
);

    localparam int AW    = $clog2(PIXEL_COUNT);
    localparam int CNT_W = $clog2(PIXEL_COUNT + 1);

    typedef enum logic [16:0] {
        S_IDLE   = 17'b1 << 0,
        S_FIN    = 17'b1 << 1,
        S_RMEM   = 17'b1 << 2,
        S_RW     = 17'b1 << 3,
        S_RT     = 17'b1 << 4,
        S_NUMW   = 17'b1 << 5,
        S_NUM    = 17'b1 << 6,
        S_DENW   = 17'b1 << 7,
        S_DEN    = 17'b1 << 8,
        S_DSTART = 17'b1 << 9,
        S_BDIV   = 17'b1 << 10,
        S_PMEM   = 17'b1 << 11,
        S_PW1    = 17'b1 << 12,
        S_PR     = 17'b1 << 13,
        S_PS     = 17'b1 << 14,
        S_PW2    = 17'b1 << 15,
        S_PACC   = 17'b1 << 16
    } t_state;

    // alpha division reuses the divider start and wait states of beta division
    t_state r_state, n_state;
    logic   r_adiv;

    logic                        w_acc;
    logic                        w_hit;
    spr_pkg::t_op                w_op;
    logic [spr_pkg::MEM_W-1:0]   w_rdata;
    logic signed [15:0]          w_rd_p;
    logic signed [31:0]          w_rd_s;
    logic signed [31:0]          w_rd_s4;
    logic [AW-1:0]               w_raddr;
    logic [CNT_W-1:0]            w_i_inc;
    logic                        w_last;

    logic [63:0]                 w_m0_a, w_m1_a;
    logic signed [32:0]          w_m0_b, w_m1_b;
    logic signed [63:0]          w_m0_p, w_m1_p;

    spr_pkg::t_div_req           w_div_req;
    logic                        w_div_done;
    logic signed [63:0]          w_div_quot;

    logic                        r_ov;
    spr_pkg::t_out_item          r_out;
    logic [31:0]                 r_sum_sq;
    logic signed [31:0]          r_sum_cr;
    logic [31:0]                 r_sum4;
    logic signed [63:0]          r_dot, r_dot4, r_alpha, r_beta;
    logic [CNT_W-1:0]            r_loaded;
    spr_pkg::t_op                r_op;
    logic                        r_hit;
    logic                        r_clr;
    logic signed [47:0]          r_prod, r_prod4;
    logic signed [15:0]          r_p;
    logic signed [31:0]          r_s;
    logic signed [63:0]          r_t, r_num, r_den, r_r, r_acc;
    logic [CNT_W-1:0]            r_i;

    logic signed [63:0]          w_p64, w_diff, w_corr;

    assign w_op       = spr_pkg::t_op'(i_in_data.operation);
    assign o_in_stall = !((r_state == S_IDLE) && (!r_ov || !i_out_stall));
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_hit      = 32'(i_in_data.pixel_index) < 32'(PIXEL_COUNT);

    assign w_rd_p  = w_rdata[spr_pkg::MEM_W-1 -: 16];
    assign w_rd_s  = w_rdata[63:32];
    assign w_rd_s4 = w_rdata[31:0];

    assign w_i_inc = r_i + CNT_W'(1);
    assign w_last  = (w_i_inc == r_loaded);

    always_comb begin
        if (r_state == S_IDLE) w_raddr = AW'(i_in_data.pixel_index);
        else if (r_state == S_PACC) w_raddr = w_i_inc[AW-1:0];
        else w_raddr = '0;
    end

    spr_ram #(
        .WIDTH(spr_pkg::MEM_W),
        .DEPTH(PIXEL_COUNT)
    ) u_pix_ram (
        .i_clk  (i_clk),
        .i_we   (w_acc && w_op == spr_pkg::OP_LOAD && w_hit),
        .i_waddr(AW'(i_in_data.pixel_index)),
        .i_wdata({i_in_data.pattern_value, i_in_data.shade_value,
                  i_in_data.shade4_value}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // operand selection for the two multipliers
    always_comb begin
        w_m0_a = '0;
        w_m0_b = '0;
        w_m1_a = '0;
        w_m1_b = '0;
        unique case (r_state)
            S_IDLE: begin
                w_m0_a = r_dot4;
                w_m0_b = {1'b0, r_sum_sq};
                w_m1_a = r_dot;
                w_m1_b = spr_pkg::sx33(r_sum_cr);
            end
            S_NUM: begin
                w_m0_a = {32'd0, r_sum_sq};
                w_m0_b = {1'b0, r_sum4};
                w_m1_a = 64'(r_sum_cr);
                w_m1_b = spr_pkg::sx33(r_sum_cr);
            end
            S_RMEM: begin
                w_m0_a = r_alpha;
                w_m0_b = spr_pkg::shade_pre(w_rd_s);
                w_m1_a = r_beta;
                w_m1_b = spr_pkg::sx33(w_rd_s4);
            end
            S_PMEM: begin
                w_m0_a = r_beta;
                w_m0_b = spr_pkg::sx33(w_rd_s4);
            end
            S_PS: begin
                w_m0_a = r_r;
                w_m0_b = spr_pkg::sx33(r_s);
            end
            default: ;
        endcase
    end

    spr_mul u_mul0 (.i_clk(i_clk), .i_a(w_m0_a), .i_b(w_m0_b), .o_p(w_m0_p));
    spr_mul u_mul1 (.i_clk(i_clk), .i_a(w_m1_a), .i_b(w_m1_b), .o_p(w_m1_p));

    always_comb begin
        w_div_req.start = (r_state == S_DSTART);
        w_div_req.num   = r_num;
        w_div_req.den   = r_den;
    end

    spr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_done (w_div_done),
        .o_quot (w_div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_op)
                        spr_pkg::OP_SOLVE: n_state = S_NUMW;
                        spr_pkg::OP_READ:  n_state = w_hit ? S_RMEM : S_FIN;
                        spr_pkg::OP_LOAD:  n_state = S_FIN;
                        spr_pkg::OP_NOP:   n_state = S_FIN;
                        default:           n_state = S_FIN;
                    endcase
                end
            end
            S_RMEM:   n_state = S_RW;
            S_RW:     n_state = S_RT;
            S_RT:     n_state = S_FIN;
            S_NUMW:   n_state = S_NUM;
            S_NUM:    n_state = S_DENW;
            S_DENW:   n_state = S_DEN;
            S_DEN:    n_state = S_DSTART;
            S_DSTART: n_state = S_BDIV;
            S_BDIV: begin
                if (w_div_done) begin
                    if (r_adiv) n_state = S_FIN;
                    else if (r_loaded == '0) n_state = S_DSTART;
                    else n_state = S_PMEM;
                end
            end
            S_PMEM:   n_state = S_PW1;
            S_PW1:    n_state = S_PR;
            S_PR:     n_state = S_PS;
            S_PS:     n_state = S_PW2;
            S_PW2:    n_state = S_PACC;
            S_PACC:   n_state = w_last ? S_DSTART : S_PMEM;
            S_FIN:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign w_p64  = 64'(r_p);
    assign w_diff = w_p64 - (r_t >>> spr_pkg::RES_SHIFT);
    assign w_corr = w_diff >>> spr_pkg::OUT_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_adiv   <= 1'b0;
            r_ov     <= 1'b0;
            r_sum_sq <= spr_pkg::RST_SUM_SQ;
            r_sum_cr <= spr_pkg::RST_SUM_CROSS;
            r_sum4   <= spr_pkg::RST_SUM4_SQ;
            r_dot    <= '0;
            r_dot4   <= '0;
            r_alpha  <= '0;
            r_beta   <= '0;
            r_loaded <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && !i_out_stall) r_ov <= 1'b0;

            if (i_cfg_we) begin
                unique case (spr_pkg::t_cfg_idx'(i_cfg_idx))
                    spr_pkg::CFG_SUM_SQ:    r_sum_sq <= i_cfg_wdata;
                    spr_pkg::CFG_SUM_CROSS: r_sum_cr <= i_cfg_wdata;
                    spr_pkg::CFG_SUM4_SQ:   r_sum4   <= i_cfg_wdata;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    r_adiv <= 1'b0;
                    if (w_acc) begin
                        r_op    <= w_op;
                        r_hit   <= w_hit;
                        r_clr   <= (i_in_data.pixel_index == '0);
                        r_prod  <= i_in_data.shade_value * i_in_data.pattern_value;
                        r_prod4 <= i_in_data.shade4_value * i_in_data.pattern_value;
                        if (w_op == spr_pkg::OP_LOAD && w_hit) begin
                            r_loaded <= CNT_W'(32'(i_in_data.pixel_index) + 1);
                        end
                    end
                end
                S_RMEM: r_p <= w_rd_p;
                S_RT:   r_t <= spr_pkg::shade_post(w_m0_p) + w_m1_p;
                S_NUM:  r_num <= spr_pkg::shift_by(w_m0_p, spr_pkg::SH_DIFF) - w_m1_p;
                S_DEN:  r_den <= (w_m0_p >>> spr_pkg::SUM_SHIFT)
                               - (w_m1_p >>> spr_pkg::SUM_SHIFT);
                S_BDIV: begin
                    if (w_div_done) begin
                        if (r_adiv) begin
                            r_alpha <= w_div_quot;
                        end else begin
                            r_beta <= w_div_quot;
                            r_i    <= '0;
                            r_acc  <= '0;
                            if (r_loaded == '0) begin
                                // empty walk: alpha = 0 / sum_shade_sq
                                r_adiv <= 1'b1;
                                r_num  <= '0;
                                r_den  <= 64'({32'd0, r_sum_sq});
                            end
                        end
                    end
                end
                S_PMEM: begin
                    r_p <= w_rd_p;
                    r_s <= w_rd_s;
                end
                S_PR: r_r <= ((w_p64 <<< spr_pkg::RES_SHIFT) - w_m0_p)
                             >>> spr_pkg::SHADE4_SHIFT;
                S_PACC: begin
                    r_acc <= r_acc + spr_pkg::shift_by(w_m0_p, spr_pkg::ACC_SHIFT);
                    r_i   <= w_i_inc;
                    if (w_last) begin
                        r_adiv <= 1'b1;
                        r_num  <= r_acc + spr_pkg::shift_by(w_m0_p, spr_pkg::ACC_SHIFT);
                        r_den  <= 64'({32'd0, r_sum_sq});
                    end
                end
                S_FIN: begin
                    if (r_op == spr_pkg::OP_LOAD && r_hit) begin
                        r_dot  <= (r_clr ? 64'sd0 : r_dot) + 64'(r_prod);
                        r_dot4 <= (r_clr ? 64'sd0 : r_dot4) + 64'(r_prod4);
                    end
                    r_ov <= 1'b1;
                    r_out.corrected_value <= (r_op == spr_pkg::OP_READ && r_hit)
                                             ? w_corr[31:0] : 32'sd0;
                    r_out.alpha_coef <= r_alpha;
                    r_out.beta_coef  <= r_beta;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while one is in progress");
    a_fin_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !r_ov)
        else $error("result written over an untaken result");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result produced without an item");
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && r_state == S_IDLE))
        else $error("reset left control state set");
`endif

endmodule

`default_nettype wire
